// ----- src/flr_pkg.sv -----
// ----------------------------------------------------------------------------
// flr_pkg: shared definitions of the fixed-point line rasteriser
// Operation codes, fixed field widths, register map and the class record
// that the front end hands to the back end for every queued item.
// ----------------------------------------------------------------------------
`default_nettype none

package flr_pkg;

	// Operation codes of the input item
	localparam logic OP_LINE    = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// Fixed field widths
	localparam int ADDR_W   = 20;
	localparam int COLOUR_W = 8;
	localparam int STRIDE_W = 11;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd1024;

	// Register bus
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// Register index, taken from the word address bit of paddr
	localparam logic [0:0] REG_ROW_STRIDE = 1'b0;

	// Classification of one queued item
	typedef struct packed {
		logic is_advance;
		logic major_y;
		logic major_neg;
		logic minor_neg;
	} line_class_t;

endpackage

`default_nettype wire

// ----- src/flr_front.sv -----
// ----------------------------------------------------------------------------
// flr_front: input classifier and item queue
// Accepts items, works out the major axis, direction and lengths of a line
// command, and holds the classified items in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module flr_front import flr_pkg::*; #(
	parameter int COORD_BITS  = 10,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire logic                  operation,
	input  wire logic [COORD_BITS-1:0] start_x,
	input  wire logic [COORD_BITS-1:0] start_y,
	input  wire logic [COORD_BITS-1:0] end_x,
	input  wire logic [COORD_BITS-1:0] end_y,
	input  wire logic [COLOUR_W-1:0]   colour,
	output logic                       q_valid,
	input  wire logic                  q_pop,
	output line_class_t                q_class,
	output logic [COORD_BITS-1:0]      q_x0,
	output logic [COORD_BITS-1:0]      q_y0,
	output logic [COLOUR_W-1:0]        q_colour,
	output logic [COORD_BITS:0]        q_minor_mag,
	output logic [COORD_BITS:0]        q_len
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic                  x_desc;
	logic                  y_desc;
	logic [COORD_BITS-1:0] dx_mag;
	logic [COORD_BITS-1:0] dy_mag;
	logic [COORD_BITS-1:0] major_mag;
	logic [COORD_BITS-1:0] minor_mag;
	line_class_t           cls;
	logic [COORD_BITS:0]   len;
	logic [COORD_BITS:0]   mag;

	logic                  push;
	logic                  full;

	line_class_t           class_mem_q  [QUEUE_DEPTH];
	logic [COORD_BITS-1:0] x0_mem_q     [QUEUE_DEPTH];
	logic [COORD_BITS-1:0] y0_mem_q     [QUEUE_DEPTH];
	logic [COLOUR_W-1:0]   colour_mem_q [QUEUE_DEPTH];
	logic [COORD_BITS:0]   mag_mem_q    [QUEUE_DEPTH];
	logic [COORD_BITS:0]   len_mem_q    [QUEUE_DEPTH];

	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;

	// Classification: the major axis is the longer one, x on a tie.
	always_comb begin
		x_desc    = start_x > end_x;
		y_desc    = start_y > end_y;
		dx_mag    = x_desc ? (start_x - end_x) : (end_x - start_x);
		dy_mag    = y_desc ? (start_y - end_y) : (end_y - start_y);
		cls.is_advance = (operation == OP_ADVANCE);
		cls.major_y    = dy_mag > dx_mag;
		cls.major_neg  = cls.major_y ? y_desc : x_desc;
		cls.minor_neg  = cls.major_y ? x_desc : y_desc;
		major_mag = cls.major_y ? dy_mag : dx_mag;
		minor_mag = cls.major_y ? dx_mag : dy_mag;
		len       = (COORD_BITS+1)'(major_mag) + (COORD_BITS+1)'(1);
		mag       = (COORD_BITS+1)'(minor_mag) + (COORD_BITS+1)'(1);
	end

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign item_stall = full;
	assign push       = item_valid && !full;
	assign q_valid    = (count_q != '0);

	assign q_class     = class_mem_q[rd_ptr_q];
	assign q_x0        = x0_mem_q[rd_ptr_q];
	assign q_y0        = y0_mem_q[rd_ptr_q];
	assign q_colour    = colour_mem_q[rd_ptr_q];
	assign q_minor_mag = mag_mem_q[rd_ptr_q];
	assign q_len       = len_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			class_mem_q[wr_ptr_q]  <= cls;
			x0_mem_q[wr_ptr_q]     <= start_x;
			y0_mem_q[wr_ptr_q]     <= start_y;
			colour_mem_q[wr_ptr_q] <= colour;
			mag_mem_q[wr_ptr_q]    <= mag;
			len_mem_q[wr_ptr_q]    <= len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/flr_div.sv -----
// ----------------------------------------------------------------------------
// flr_div: iterative divider for the minor-axis step
// Restoring division of (magnitude << FRAC_BITS) by the line length, one
// quotient bit per cycle; the quotient never exceeds 1 << FRAC_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module flr_div #(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [COORD_BITS:0]   magnitude,
	input  wire logic [COORD_BITS:0]   divisor,
	output logic                       done,
	output logic [FRAC_BITS:0]         quotient
);

	localparam int CNT_W = $clog2(FRAC_BITS + 2);

	logic [COORD_BITS:0]   rem_q;
	logic [FRAC_BITS:0]    dvd_q;
	logic [FRAC_BITS:0]    quo_q;
	logic [COORD_BITS:0]   div_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;

	logic [COORD_BITS+1:0] trial;
	logic [COORD_BITS+1:0] diff;
	logic                  fits;

	// Since magnitude <= divisor, the top of the dividend above the
	// quotient bits is already smaller than the divisor, so only
	// FRAC_BITS + 1 steps are needed.
	always_comb begin
		trial = {rem_q, dvd_q[FRAC_BITS]};
		diff  = trial - {1'b0, div_q};
		fits  = trial >= {1'b0, div_q};
	end

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, magnitude[COORD_BITS:1]};
			dvd_q <= {magnitude[0], {FRAC_BITS{1'b0}}};
			quo_q <= '0;
			div_q <= divisor;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= fits ? diff[COORD_BITS:0] : trial[COORD_BITS:0];
			dvd_q <= {dvd_q[FRAC_BITS-1:0], 1'b0};
			quo_q <= {quo_q[FRAC_BITS-1:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(FRAC_BITS + 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/flr_back.sv -----
// ----------------------------------------------------------------------------
// flr_back: DDA stepper and result register
// Sets up a line from a queued command, waits for the minor step from the
// divider, then walks the line one pixel per advance into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module flr_back import flr_pkg::*; #(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [STRIDE_W-1:0]   row_stride,
	input  wire logic                  q_valid,
	output logic                       q_pop,
	input  wire line_class_t           q_class,
	input  wire logic [COORD_BITS-1:0] q_x0,
	input  wire logic [COORD_BITS-1:0] q_y0,
	input  wire logic [COLOUR_W-1:0]   q_colour,
	input  wire logic [COORD_BITS:0]   q_minor_mag,
	input  wire logic [COORD_BITS:0]   q_len,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic [ADDR_W-1:0]          pixel_address,
	output logic [COLOUR_W-1:0]        pixel_colour,
	output logic                       pixel_valid,
	output logic                       last_pixel
);

	localparam int ACC_W  = COORD_BITS + FRAC_BITS + 2;
	localparam int STEP_W = FRAC_BITS + 2;
	localparam int PROD_W = COORD_BITS + STRIDE_W;
	localparam int SUM_W  = PROD_W + 1;

	localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1) << FRAC_BITS;

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic [COORD_BITS:0]   pixels_left_q;
	logic                  out_valid_q;

	logic [ACC_W-1:0]      acc_x_q;
	logic [ACC_W-1:0]      acc_y_q;
	logic [STEP_W-1:0]     step_x_q;
	logic [STEP_W-1:0]     step_y_q;
	logic [COLOUR_W-1:0]   colour_q;
	logic                  major_y_q;
	logic                  minor_neg_q;

	logic [ADDR_W-1:0]     address_q;
	logic [COLOUR_W-1:0]   pix_colour_q;
	logic                  pix_valid_q;
	logic                  last_q;

	logic                  out_free;
	logic                  have_pixel;
	logic                  take_adv;
	logic                  take_line;
	logic                  emit_setup;
	logic                  do_emit;
	logic                  load_out;
	logic                  div_done;
	logic [FRAC_BITS:0]    div_quotient;
	logic [STEP_W-1:0]     minor_mag;
	logic [STEP_W-1:0]     minor_step;
	logic [COORD_BITS-1:0] coord_x;
	logic [COORD_BITS-1:0] coord_y;
	logic [PROD_W-1:0]     prod;
	logic [SUM_W-1:0]      sum;
	logic [ADDR_W-1:0]     address;

	flr_div #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (take_line),
		.magnitude (q_minor_mag),
		.divisor   (q_len),
		.done      (div_done),
		.quotient  (div_quotient)
	);

	// A position below zero only happens on an undershooting minor axis
	// and reads as coordinate zero.
	always_comb begin
		coord_x = acc_x_q[ACC_W-1] ? '0 : acc_x_q[FRAC_BITS +: COORD_BITS];
		coord_y = acc_y_q[ACC_W-1] ? '0 : acc_y_q[FRAC_BITS +: COORD_BITS];
		prod    = PROD_W'(coord_y) * PROD_W'(row_stride);
		sum     = SUM_W'(prod) + SUM_W'(coord_x);
		address = ADDR_W'(sum);
	end

	always_comb begin
		minor_mag  = {1'b0, div_quotient};
		minor_step = minor_neg_q ? -minor_mag : minor_mag;
	end

	assign out_free   = !out_valid_q || !result_stall;
	assign have_pixel = (pixels_left_q != '0);
	assign take_adv   = (state_q == ST_RUN) && q_valid && q_class.is_advance && out_free;
	assign take_line  = (state_q == ST_RUN) && q_valid && !q_class.is_advance;
	assign emit_setup = (state_q == ST_EMIT) && out_free;
	assign do_emit    = (take_adv && have_pixel) || emit_setup;
	assign load_out   = take_adv || emit_setup;
	assign q_pop      = take_adv || take_line;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_RUN;
			pixels_left_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (take_line) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase

			if (take_line) begin
				pixels_left_q <= q_len;
			end else if (do_emit) begin
				pixels_left_q <= pixels_left_q - 1'b1;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_line) begin
			acc_x_q     <= {2'b00, q_x0, {FRAC_BITS{1'b0}}};
			acc_y_q     <= {2'b00, q_y0, {FRAC_BITS{1'b0}}};
			colour_q    <= q_colour;
			major_y_q   <= q_class.major_y;
			minor_neg_q <= q_class.minor_neg;
			if (q_class.major_y) begin
				step_y_q <= q_class.major_neg ? -STEP_ONE : STEP_ONE;
			end else begin
				step_x_q <= q_class.major_neg ? -STEP_ONE : STEP_ONE;
			end
		end else if (div_done) begin
			if (major_y_q) begin
				step_x_q <= minor_step;
			end else begin
				step_y_q <= minor_step;
			end
		end else if (do_emit) begin
			acc_x_q <= acc_x_q + {{COORD_BITS{step_x_q[STEP_W-1]}}, step_x_q};
			acc_y_q <= acc_y_q + {{COORD_BITS{step_y_q[STEP_W-1]}}, step_y_q};
		end

		if (load_out) begin
			address_q    <= have_pixel ? address : '0;
			pix_colour_q <= have_pixel ? colour_q : '0;
			pix_valid_q  <= have_pixel;
			last_q       <= (pixels_left_q == (COORD_BITS+1)'(1));
		end
	end

	assign result_valid  = out_valid_q;
	assign pixel_address = address_q;
	assign pixel_colour  = pix_colour_q;
	assign pixel_valid   = pix_valid_q;
	assign last_pixel    = last_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished while no line set-up was waiting");

	a_emit_has_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (pixels_left_q != '0))
		else $error("first pixel of a line pending with no pixels left");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (pixels_left_q == (COORD_BITS+1)'(1))) |=> (pixels_left_q == '0))
		else $error("line still running after its last pixel");

	a_pop_only_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |-> !q_pop)
		else $error("queue popped while a line set-up was in progress");

endmodule

`default_nettype wire

// ----- src/fixed_point_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// fixed_point_line_rasterizer: DDA line rasteriser in fixed point
// An advance transfer passes through the queue into the result register,
// and advances stream at one per cycle while the result side keeps up
// and no line set-up is in progress. A line command holds the back end
// while the one-bit-per-cycle divider works out the minor step; its
// first pixel then goes into the result register.
// Reset clears the queue, the line state and the output; row_stride is 1024.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_line_rasterizer import flr_pkg::*; #(
	parameter int COORD_BITS  = 10,
	parameter int FRAC_BITS   = 10,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	// Register port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,

	// Item channel
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire logic                  operation,
	input  wire logic [COORD_BITS-1:0] start_x,
	input  wire logic [COORD_BITS-1:0] start_y,
	input  wire logic [COORD_BITS-1:0] end_x,
	input  wire logic [COORD_BITS-1:0] end_y,
	input  wire logic [COLOUR_W-1:0]   colour,

	// Result channel
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic [ADDR_W-1:0]          pixel_address,
	output logic [COLOUR_W-1:0]        pixel_colour,
	output logic                       pixel_valid,
	output logic                       last_pixel
);

	logic [STRIDE_W-1:0]   row_stride_q;
	logic                  reg_sel;
	logic                  reg_write;

	logic                  q_valid;
	logic                  q_pop;
	line_class_t           q_class;
	logic [COORD_BITS-1:0] q_x0;
	logic [COORD_BITS-1:0] q_y0;
	logic [COLOUR_W-1:0]   q_colour;
	logic [COORD_BITS:0]   q_minor_mag;
	logic [COORD_BITS:0]   q_len;

	// The register port never waits. There is a single register, row_stride,
	// at byte address 0; the word address bit picks it and any write to the
	// other word is dropped. Reads of that word return zero.
	assign pready    = 1'b1;
	assign reg_sel   = (paddr[2:2] == REG_ROW_STRIDE);
	assign reg_write = psel && penable && pwrite && pready && reg_sel;
	assign prdata    = reg_sel ? APB_DATA_W'(row_stride_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_stride_q <= STRIDE_RESET;
		end else if (reg_write) begin
			row_stride_q <= pwdata[STRIDE_W-1:0];
		end
	end

	// The front end accepts a transfer whenever its queue has room and does
	// the per-command classification (major axis, directions, line length)
	// on the way in, so the back end only sees ready-made set-up values.
	flr_front #(
		.COORD_BITS  (COORD_BITS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.operation   (operation),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.colour      (colour),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_class     (q_class),
		.q_x0        (q_x0),
		.q_y0        (q_y0),
		.q_colour    (q_colour),
		.q_minor_mag (q_minor_mag),
		.q_len       (q_len)
	);

	// The back end drains the queue. An advance goes straight into the
	// result register; a command loads the start position and
	// the major step, runs the divider for the minor step, and then emits
	// the line's first pixel. A command arriving mid-line simply replaces
	// the running line. The result register is the only buffer on the
	// output side, so advances and first pixels wait while a result waits
	// to be taken, and the queue keeps accepting while it has room.
	flr_back #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.row_stride    (row_stride_q),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_class       (q_class),
		.q_x0          (q_x0),
		.q_y0          (q_y0),
		.q_colour      (q_colour),
		.q_minor_mag   (q_minor_mag),
		.q_len         (q_len),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.pixel_address (pixel_address),
		.pixel_colour  (pixel_colour),
		.pixel_valid   (pixel_valid),
		.last_pixel    (last_pixel)
	);

endmodule

`default_nettype wire
